FILE: hdl/vibration_window_rms_assert.svh
// ----------------------------------------------------------------------------
// Assertion macros for the vibration window RMS block
// Clocked on clk, disabled while rst_n is low.
// ----------------------------------------------------------------------------
`ifndef VIBRATION_WINDOW_RMS_ASSERT_SVH
`define VIBRATION_WINDOW_RMS_ASSERT_SVH

// Same-cycle implication
`define VWR_ASSERT_IMP(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication
`define VWR_ASSERT_NXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

FILE: hdl/vwr_pkg.sv
// ----------------------------------------------------------------------------
// vwr_pkg
// Shared widths and types of the three-axis moving-window RMS block.
// ----------------------------------------------------------------------------
`default_nettype none

package vwr_pkg;

    // Window depth (any value 2..4096)
    localparam int WINDOW_DEPTH = 64;
    localparam int SLOT_W       = $clog2(WINDOW_DEPTH);

    // Sample layout
    localparam int AXIS_W   = 16;
    localparam int SAMPLE_W = 3 * AXIS_W;

    // One axis squared is at most 2^30; three of them stay below 2^32
    localparam int SQ_W     = 2 * AXIS_W - 1;
    localparam int TRIPLE_W = 2 * AXIS_W;

    // Window energy: below WINDOW_DEPTH * 2^32
    localparam int ENERGY_W = SLOT_W + TRIPLE_W;

    // Root result and step counter
    localparam int ROOT_W      = 16;
    localparam int ROOT_STEP_W = $clog2(ROOT_W);

    // Squares produced by one lane
    typedef struct packed {
        logic [SQ_W-1:0] new_sq;
        logic [SQ_W-1:0] old_sq;
    } lane_sq_t;

endpackage

`default_nettype wire

FILE: hdl/vwr_ram.sv
// ----------------------------------------------------------------------------
// vwr_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
`default_nettype none

module vwr_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  wire logic                     clk,
    input  wire logic                     we,
    input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
    input  wire logic [WIDTH-1:0]         wr_data,
    input  wire logic                     rd_en,
    input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic      [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];

    // Write port
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[wr_addr] <= wr_data;
        end
    end

    // Registered read port
    always_ff @(posedge clk)
    begin
        if (rd_en)
        begin
            rd_data <= mem[rd_addr];
        end
    end

endmodule

`default_nettype wire

FILE: hdl/vwr_lane.sv
// ----------------------------------------------------------------------------
// vwr_lane
// One axis lane: squares the incoming and the overwritten value of an axis.
// ----------------------------------------------------------------------------
`default_nettype none

module vwr_lane (
    input  wire logic                                clk,
    input  wire logic                                load,
    input  wire logic signed [vwr_pkg::AXIS_W-1:0]   new_axis,
    input  wire logic signed [vwr_pkg::AXIS_W-1:0]   old_axis,
    input  wire logic                                old_valid,
    output vwr_pkg::lane_sq_t                        sq
);

    logic signed [vwr_pkg::AXIS_W-1:0]   old_masked;
    logic signed [2*vwr_pkg::AXIS_W-1:0] new_prod;
    logic signed [2*vwr_pkg::AXIS_W-1:0] old_prod;
    vwr_pkg::lane_sq_t                   sq_reg;

    // Entries never written since reset read as zero
    assign old_masked = old_valid ? old_axis : '0;

    // Squares are never negative and fit in SQ_W bits
    assign new_prod = new_axis * new_axis;
    assign old_prod = old_masked * old_masked;

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            sq_reg.new_sq <= new_prod[vwr_pkg::SQ_W-1:0];
            sq_reg.old_sq <= old_prod[vwr_pkg::SQ_W-1:0];
        end
    end

    assign sq = sq_reg;

endmodule

`default_nettype wire

FILE: hdl/vwr_merge.sv
// ----------------------------------------------------------------------------
// vwr_merge
// Merges the three lanes and keeps the running window energy.
// ----------------------------------------------------------------------------
`default_nettype none

module vwr_merge (
    input  wire logic                           clk,
    input  wire logic                           rst_n,
    input  wire logic                           update,
    input  wire vwr_pkg::lane_sq_t              lane_x,
    input  wire vwr_pkg::lane_sq_t              lane_y,
    input  wire vwr_pkg::lane_sq_t              lane_z,
    output logic [vwr_pkg::ENERGY_W-1:0]        energy_total
);

    logic [vwr_pkg::TRIPLE_W-1:0] new_sum;
    logic [vwr_pkg::TRIPLE_W-1:0] old_sum;
    logic [vwr_pkg::ENERGY_W-1:0] energy_total_reg;
    logic [vwr_pkg::ENERGY_W-1:0] energy_total_next;

    // Per-sample energies, new and overwritten
    assign new_sum = vwr_pkg::TRIPLE_W'(lane_x.new_sq) + vwr_pkg::TRIPLE_W'(lane_y.new_sq)
                   + vwr_pkg::TRIPLE_W'(lane_z.new_sq);
    assign old_sum = vwr_pkg::TRIPLE_W'(lane_x.old_sq) + vwr_pkg::TRIPLE_W'(lane_y.old_sq)
                   + vwr_pkg::TRIPLE_W'(lane_z.old_sq);

    // Old energy is always part of the total, so no underflow
    assign energy_total_next = energy_total_reg - vwr_pkg::ENERGY_W'(old_sum)
                             + vwr_pkg::ENERGY_W'(new_sum);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            energy_total_reg <= '0;
        end
        else if (update)
        begin
            energy_total_reg <= energy_total_next;
        end
    end

    assign energy_total = energy_total_reg;

endmodule

`default_nettype wire

FILE: hdl/vwr_root.sv
// ----------------------------------------------------------------------------
// vwr_root
// Iterative root of the window mean: largest r with r*r*WINDOW_DEPTH <= E,
// one result bit per cycle, with shifted partial products kept in registers.
// ----------------------------------------------------------------------------
`default_nettype none

module vwr_root (
    input  wire logic                           clk,
    input  wire logic                           rst_n,
    input  wire logic                           start,
    input  wire logic [vwr_pkg::ENERGY_W-1:0]   energy,
    output logic                                busy,
    output logic [vwr_pkg::ROOT_W-1:0]          root
);

    localparam logic [vwr_pkg::ENERGY_W-1:0] DEPTH_TOP =
        vwr_pkg::ENERGY_W'(vwr_pkg::WINDOW_DEPTH) << (2 * (vwr_pkg::ROOT_W - 1));

    logic                              busy_reg;
    logic [vwr_pkg::ROOT_STEP_W-1:0]   step_reg;
    logic [vwr_pkg::ENERGY_W-1:0]      energy_reg;
    logic [vwr_pkg::ENERGY_W-1:0]      sq_reg;     // r*r*D
    logic [vwr_pkg::ENERGY_W-1:0]      cross_reg;  // r*D << (k+1)
    logic [vwr_pkg::ENERGY_W-1:0]      bit_reg;    // D << 2k
    logic [vwr_pkg::ROOT_W-1:0]        root_reg;
    logic [vwr_pkg::ENERGY_W-1:0]      cand;
    logic                              take;

    // Candidate (r + 2^k)^2 * D
    assign cand = sq_reg + cross_reg + bit_reg;
    assign take = (cand <= energy_reg);

    // Control
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            step_reg <= '0;
        end
        else if (start)
        begin
            busy_reg <= 1'b1;
            step_reg <= vwr_pkg::ROOT_STEP_W'(vwr_pkg::ROOT_W - 1);
        end
        else if (busy_reg)
        begin
            if (step_reg == '0)
            begin
                busy_reg <= 1'b0;
            end
            step_reg <= step_reg - 1'b1;
        end
    end

    // Datapath
    always_ff @(posedge clk)
    begin
        if (start)
        begin
            energy_reg <= energy;
            sq_reg     <= '0;
            cross_reg  <= '0;
            bit_reg    <= DEPTH_TOP;
            root_reg   <= '0;
        end
        else if (busy_reg)
        begin
            bit_reg <= bit_reg >> 2;
            if (take)
            begin
                sq_reg             <= cand;
                cross_reg          <= (cross_reg >> 1) + bit_reg;
                root_reg[step_reg] <= 1'b1;
            end
            else
            begin
                cross_reg <= cross_reg >> 1;
            end
        end
    end

    assign busy = busy_reg;
    assign root = root_reg;

endmodule

`default_nettype wire

FILE: hdl/vibration_window_rms.sv
// ----------------------------------------------------------------------------
// vibration_window_rms
// Three-axis moving-window RMS over the last WINDOW_DEPTH samples.
// ----------------------------------------------------------------------------
//  Channel   Dir   Bits  Contents
//  s_axis    in    48    accel_x [15:0], accel_y [31:16], accel_z [47:32]
//  m_axis    out   16    rms_level [15:0]
//
//  A request passes lane squaring, energy merge, root start, the bit-serial
//  root unit and the load of its result into the output register. The root
//  unit sets the rate: the block takes no new request while one is in
//  flight. The next request is taken once the result is in the output
//  register, even while it waits to be taken downstream.
//  Reset clears the energy, the write slot and the fill flag; window entries
//  not yet written read as zero. A stalled output holds the block before the
//  root result is loaded.
// ----------------------------------------------------------------------------
`default_nettype none

`include "vibration_window_rms_assert.svh"

module vibration_window_rms (
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        s_tvalid,
    output logic             s_tready,
    input  wire logic [47:0] s_tdata,   // accel_x, accel_y, accel_z
    output logic             m_tvalid,
    input  wire logic        m_tready,
    output logic [15:0]      m_tdata    // rms_level
);

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_LANE,
        ST_MERGE,
        ST_START,
        ST_ROOT,
        ST_HOLD
    } state_t;

    state_t                              state_reg;
    logic [vwr_pkg::SLOT_W-1:0]          write_slot_reg;
    logic                                wrapped_reg;
    logic [vwr_pkg::SAMPLE_W-1:0]        sample_reg;
    logic                                m_tvalid_reg;
    logic [vwr_pkg::ROOT_W-1:0]          m_tdata_reg;

    logic                                s_accept;
    logic                                out_free;
    logic                                result_load;
    logic [vwr_pkg::SAMPLE_W-1:0]        old_sample;
    vwr_pkg::lane_sq_t                   lane_x_sq;
    vwr_pkg::lane_sq_t                   lane_y_sq;
    vwr_pkg::lane_sq_t                   lane_z_sq;
    logic [vwr_pkg::ENERGY_W-1:0]        energy_total;
    logic                                root_busy;
    logic [vwr_pkg::ROOT_W-1:0]          root;

    assign s_tready = (state_reg == ST_IDLE);
    assign s_accept = s_tvalid && s_tready;
    assign out_free = !m_tvalid_reg || m_tready;

    // Root done and output register free
    assign result_load = ((state_reg == ST_ROOT) || (state_reg == ST_HOLD))
                         && !root_busy && out_free;

    // Sample window
    vwr_ram #(
        .WIDTH (vwr_pkg::SAMPLE_W),
        .DEPTH (vwr_pkg::WINDOW_DEPTH)
    ) u_window (
        .clk     (clk),
        .we      (state_reg == ST_MERGE),
        .wr_addr (write_slot_reg),
        .wr_data (sample_reg),
        .rd_en   (s_accept),
        .rd_addr (write_slot_reg),
        .rd_data (old_sample)
    );

    // Axis lanes
    vwr_lane u_lane_x (
        .clk       (clk),
        .load      (state_reg == ST_LANE),
        .new_axis  (sample_reg[vwr_pkg::AXIS_W-1:0]),
        .old_axis  (old_sample[vwr_pkg::AXIS_W-1:0]),
        .old_valid (wrapped_reg),
        .sq        (lane_x_sq)
    );

    vwr_lane u_lane_y (
        .clk       (clk),
        .load      (state_reg == ST_LANE),
        .new_axis  (sample_reg[2*vwr_pkg::AXIS_W-1:vwr_pkg::AXIS_W]),
        .old_axis  (old_sample[2*vwr_pkg::AXIS_W-1:vwr_pkg::AXIS_W]),
        .old_valid (wrapped_reg),
        .sq        (lane_y_sq)
    );

    vwr_lane u_lane_z (
        .clk       (clk),
        .load      (state_reg == ST_LANE),
        .new_axis  (sample_reg[3*vwr_pkg::AXIS_W-1:2*vwr_pkg::AXIS_W]),
        .old_axis  (old_sample[3*vwr_pkg::AXIS_W-1:2*vwr_pkg::AXIS_W]),
        .old_valid (wrapped_reg),
        .sq        (lane_z_sq)
    );

    // Energy merge
    vwr_merge u_merge (
        .clk          (clk),
        .rst_n        (rst_n),
        .update       (state_reg == ST_MERGE),
        .lane_x       (lane_x_sq),
        .lane_y       (lane_y_sq),
        .lane_z       (lane_z_sq),
        .energy_total (energy_total)
    );

    // Root of the mean
    vwr_root u_root (
        .clk    (clk),
        .rst_n  (rst_n),
        .start  (state_reg == ST_START),
        .energy (energy_total),
        .busy   (root_busy),
        .root   (root)
    );

    // Incoming sample, held for the lanes and the window write
    always_ff @(posedge clk)
    begin
        if (s_accept)
        begin
            sample_reg <= s_tdata;
        end
    end

    // Sequencer, write slot and output register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= ST_IDLE;
            write_slot_reg <= '0;
            wrapped_reg    <= 1'b0;
            m_tvalid_reg   <= 1'b0;
            m_tdata_reg    <= '0;
        end
        else
        begin
            if (result_load)
            begin
                m_tvalid_reg <= 1'b1;
                m_tdata_reg  <= root;
            end
            else if (m_tvalid_reg && m_tready)
            begin
                m_tvalid_reg <= 1'b0;
            end
            unique case (state_reg)
                ST_IDLE:
                begin
                    if (s_accept)
                    begin
                        state_reg <= ST_LANE;
                    end
                end
                ST_LANE:
                begin
                    state_reg <= ST_MERGE;
                end
                ST_MERGE:
                begin
                    if (write_slot_reg == vwr_pkg::SLOT_W'(vwr_pkg::WINDOW_DEPTH - 1))
                    begin
                        write_slot_reg <= '0;
                        wrapped_reg    <= 1'b1;
                    end
                    else
                    begin
                        write_slot_reg <= write_slot_reg + 1'b1;
                    end
                    state_reg <= ST_START;
                end
                ST_START:
                begin
                    state_reg <= ST_ROOT;
                end
                ST_ROOT, ST_HOLD:
                begin
                    if (!root_busy)
                    begin
                        if (out_free)
                        begin
                            state_reg <= ST_IDLE;
                        end
                        else
                        begin
                            state_reg <= ST_HOLD;
                        end
                    end
                end
                default:
                begin
                    state_reg <= ST_IDLE;
                end
            endcase
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;

    // Checks
    `VWR_ASSERT_IMP(a_out_from_root, m_tvalid_reg && !$past(m_tvalid_reg), ($past(state_reg) == ST_ROOT) || ($past(state_reg) == ST_HOLD), "result loaded outside root wait")
    `VWR_ASSERT_IMP(a_slot_moves_on_merge, write_slot_reg != $past(write_slot_reg), $past(state_reg) == ST_MERGE, "write slot moved outside merge")
    `VWR_ASSERT_IMP(a_wrap_sticky, 1'b1, !$fell(wrapped_reg), "fill flag cleared after wrap")
    `VWR_ASSERT_IMP(a_root_in_wait, root_busy, state_reg == ST_ROOT, "root unit busy outside root wait")
    `VWR_ASSERT_NXT(a_root_starts, state_reg == ST_START, root_busy, "root unit did not start")

endmodule

`default_nettype wire

FILE: test/tb_vibration_window_rms.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_vibration_window_rms
// Self-checking bench for the three-axis moving-window RMS block.
// Accelerometer samples go in through the input stream. A behavioral copy of
// the 64-entry window and its energy sum predicts each rms_level, and the
// result stream is compared against it in order. Both sides stall at random,
// with one stretch where neither side idles.
// ----------------------------------------------------------------------------

module tb_vibration_window_rms;

    localparam int WINDOW_DEPTH   = vwr_pkg::WINDOW_DEPTH;
    localparam int WATCHDOG_LIMIT = 2000;
    localparam int IDLE_PCT       = 21;
    localparam int DRAIN_CYCLES   = 40;

    typedef struct packed {
        logic signed [15:0] x;
        logic signed [15:0] y;
        logic signed [15:0] z;
    } accel_sample_t;

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        s_tvalid = 1'b0;
    logic        s_tready;
    logic [47:0] s_tdata = '0;   // accel_x [15:0], accel_y [31:16], accel_z [47:32]
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    logic [15:0] m_tdata;        // rms_level [15:0]

    // Behavioral window state, zero like the block's unwritten window entries
    accel_sample_t     window_copy [WINDOW_DEPTH] = '{default: '0};
    int unsigned       next_slot = 0;
    longint unsigned   window_energy = 0;

    logic [15:0] rms_expected [$];
    int          error_count = 0;
    int          idle_cycles = 0;
    bit          no_idle;

    vibration_window_rms DUT (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata)
    );

    // 10 ns clock
    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    // Floor square root, built one result bit at a time from the top
    function automatic logic [15:0] floor_root(input longint unsigned v);
        logic [15:0]     r;
        longint unsigned trial;
        r = '0;
        for (int b = 15; b >= 0; b--)
        begin
            trial = longint'(r | (16'h1 << b));
            if (trial * trial <= v)
                r = r | (16'h1 << b);
        end
        return r;
    endfunction

    function automatic longint unsigned sample_energy(input accel_sample_t s);
        int sx, sy, sz;
        sx = s.x;
        sy = s.y;
        sz = s.z;
        return longint'(sx * sx) + longint'(sy * sy) + longint'(sz * sz);
    endfunction

    // Overwrite the oldest entry and return the new window RMS
    function automatic logic [15:0] window_rms_after(input logic [47:0] raw);
        accel_sample_t s;
        s.x = raw[15:0];
        s.y = raw[31:16];
        s.z = raw[47:32];
        window_energy = window_energy - sample_energy(window_copy[next_slot])
                        + sample_energy(s);
        window_copy[next_slot] = s;
        next_slot = (next_slot + 1) % WINDOW_DEPTH;
        return floor_root(window_energy / WINDOW_DEPTH);
    endfunction

    // Predict on every accepted request
    always @(posedge clk)
    begin
        if (rst_n && s_tvalid && s_tready)
            rms_expected.push_back(window_rms_after(s_tdata));
    end

    // Result checker and output backpressure
    always @(posedge clk)
    begin : rms_check
        logic [15:0] want;
        if (rst_n && m_tvalid && m_tready)
        begin
            if (rms_expected.size() == 0)
            begin
                error_count++;
                $display("%0t ERROR unexpected result: expected none, actual %0d",
                         $time, m_tdata);
            end
            else
            begin
                want = rms_expected.pop_front();
                if (m_tdata !== want)
                begin
                    error_count++;
                    $display("%0t ERROR rms_level: expected %0d, actual %0d",
                             $time, want, m_tdata);
                end
            end
        end
        m_tready <= no_idle || ($urandom_range(99) >= IDLE_PCT);
    end

    // Watchdog: too long without any handshake on either side
    always @(posedge clk)
    begin
        if (!rst_n || (s_tvalid && s_tready) || (m_tvalid && m_tready))
            idle_cycles <= 0;
        else if (idle_cycles >= WATCHDOG_LIMIT)
        begin
            $display("%0t ERROR watchdog: no handshake for %0d cycles",
                     $time, WATCHDOG_LIMIT);
            $display("Simulation FAILED");
            $finish;
        end
        else
            idle_cycles <= idle_cycles + 1;
    end

    // Send one sample, with an optional random gap in front of it
    task automatic send_sample(input logic [15:0] ax, input logic [15:0] ay,
                               input logic [15:0] az);
        if (!no_idle && $urandom_range(99) < IDLE_PCT)
        begin
            s_tvalid <= 1'b0;
            repeat ($urandom_range(1, 25)) @(posedge clk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= {az, ay, ax};
        @(posedge clk);
        while (!s_tready)
            @(posedge clk);
    endtask

    function automatic logic [15:0] extreme_axis();
        case ($urandom_range(4))
            0:       return 16'h8000;
            1:       return 16'h7FFF;
            2:       return 16'hFFFF;
            3:       return 16'h0001;
            default: return 16'h0000;
        endcase
    endfunction

    function automatic logic [15:0] mixed_axis(input int unsigned flavor);
        case (flavor)
            0, 1, 2, 3, 4: return 16'($urandom);
            5, 6:          return 16'($signed($urandom_range(512)) - 256);
            7:             return extreme_axis();
            default:       return 16'h0000;
        endcase
    endfunction

    // Zero, full scale, largest magnitude, sign and bit patterns; window not full
    task automatic test_directed_corners();
        send_sample(16'h0000, 16'h0000, 16'h0000);
        send_sample(16'h7FFF, 16'h7FFF, 16'h7FFF);
        send_sample(16'h8000, 16'h8000, 16'h8000);
        send_sample(16'h8000, 16'h7FFF, 16'h0000);
        send_sample(16'h0001, 16'hFFFF, 16'h0001);
        send_sample(16'hFFFF, 16'hFFFF, 16'hFFFF);
        send_sample(16'h0000, 16'h0000, 16'h8000);
        send_sample(16'h7FFF, 16'h0000, 16'h0000);
        send_sample(16'h0000, 16'h7FFF, 16'h0000);
        send_sample(16'h5555, 16'hAAAA, 16'h5555);
        send_sample(16'hAAAA, 16'h5555, 16'hAAAA);
        send_sample(16'h00FF, 16'hFF00, 16'h0F0F);
    endtask

    // Mixed random content: full range, small values, extremes, zeros
    task automatic test_random_samples(input int count);
        int unsigned flavor;
        repeat (count)
        begin
            flavor = $urandom_range(9);
            send_sample(mixed_axis(flavor), mixed_axis(flavor), mixed_axis(flavor));
        end
    endtask

    // Back-to-back traffic, neither side idling
    task automatic test_no_idle_stretch();
        no_idle = 1'b1;
        test_random_samples(250);
        no_idle = 1'b0;
    endtask

    // Fill the window at full scale, then flush it back to zero energy
    task automatic test_full_scale_window();
        repeat (WINDOW_DEPTH + 16)
            send_sample($urandom_range(1) ? 16'h8000 : 16'h7FFF,
                        $urandom_range(1) ? 16'h8000 : 16'h7FFF,
                        $urandom_range(1) ? 16'h8000 : 16'h7FFF);
        repeat (WINDOW_DEPTH + 6)
            send_sample(16'h0000, 16'h0000, 16'h0000);
    endtask

    initial
    begin
        no_idle = 1'b0;

        repeat (11) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_directed_corners();
        test_random_samples(500);
        test_no_idle_stretch();
        test_full_scale_window();
        test_random_samples(450);
        s_tvalid <= 1'b0;

        // Drain outstanding results, then let the pipeline settle
        while (rms_expected.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);

        if (error_count == 0)
            $display("Simulation PASSED");
        else
            $display("Simulation FAILED");
        $finish;
    end

endmodule
